@@ src/track_fragment_run_parser_core_defines.svh @@
// Assertion macros shared by the checker of the trun parser core.
// Depends on nothing; the asserting module supplies clk_i and rst_ni.
`ifndef TRACK_FRAGMENT_RUN_PARSER_CORE_DEFINES_SVH
`define TRACK_FRAGMENT_RUN_PARSER_CORE_DEFINES_SVH

// Checked at every rising edge outside of reset.
`define TFRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define TFRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/tfrp_pkg.sv @@
// Types and constants of the trun parser core: word structs, config codes,
// header layout. Depends on nothing.
package tfrp_pkg;

  // One payload byte of a run box with its framing marks.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       box_first;
    logic       box_last;
    logic       new_fragment;
  } tfrp_in_t;

  // Fragment totals reported at the end of each run box.
  typedef struct packed {
    logic [31:0]        fragment_samples;
    logic [63:0]        fragment_duration;
    logic [63:0]        fragment_bytes;
    logic [31:0]        run_count;
    logic               offset_flag;
    logic signed [31:0] first_offset;
    logic               box_ignored;
  } tfrp_out_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgDefaultDuration = 2'd0,
    CfgDefaultSize     = 2'd1,
    CfgMaxSamples      = 2'd2
  } tfrp_cfg_e;

  localparam logic [31:0] MaxSamplesReset = 32'd65536;

  // Bit positions inside the 24-bit run flags.
  localparam int unsigned FlagDataOffset = 0;
  localparam int unsigned FlagFirstFlags = 2;
  localparam int unsigned FlagDuration   = 8;
  localparam int unsigned FlagSize       = 9;
  localparam int unsigned RecFieldCount  = 4;

  // Byte positions within the payload. Positions past the optional header
  // all behave alike, so the position counter saturates at PosSat.
  localparam int unsigned PosW         = 5;
  localparam logic [4:0]  PosFlagsEnd  = 5'd3;
  localparam logic [4:0]  PosCountEnd  = 5'd7;
  localparam logic [4:0]  PosOffsetEnd = 5'd11;
  localparam logic [4:0]  HdrBase      = 5'd8;
  localparam logic [4:0]  OptFieldLen  = 5'd4;
  localparam logic [4:0]  PosSat       = 5'd16;

endpackage

@@ src/track_fragment_run_parser_core.sv @@
// Top level of the trun payload parser: byte parser, count stage,
// multiply stage and fragment accumulators. Depends on tfrp_pkg.
//
// The core takes one trun payload byte per cycle and, on the byte marked
// box_last, returns one word with the running fragment totals. Bytes are
// accepted back to back; in_ready_o only drops in a cycle where a finished
// result sits in the output register untaken while the next result is
// ready to move into it. After its last byte is accepted, a result is
// registered in turn: first the parsed byte and the number of samples it
// closes (including the bulk of unread samples at box end, capped by
// max_samples), then the two 32x32 products of that count less one with
// the default duration and size, then the sums added into the 64-bit
// fragment totals, loaded into the output register with out_valid_o.
// The configuration port writes a register in the cycle its enable is
// high; it is meant to be written only while no box result is still on
// its way out.
module track_fragment_run_parser_core
  import tfrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tfrp_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tfrp_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // Totals of a result that are known when its last byte is parsed.
  typedef struct packed {
    logic [31:0] samples;
    logic [31:0] runs;
    logic        offset_flag;
    logic [31:0] offset;
    logic        ignored;
  } snap_t;

  // Work of one byte after the parse stage. An all-zero word is a bubble.
  typedef struct packed {
    logic        clr;
    logic        res;
    logic [31:0] mcnt;
    logic [31:0] xdur;
    logic [31:0] xsize;
    snap_t       snap;
  } cnt_slot_t;

  // Work of one byte after the multiply stage.
  typedef struct packed {
    logic        clr;
    logic        res;
    logic [63:0] pdur;
    logic [63:0] psize;
    logic [31:0] xdur;
    logic [31:0] xsize;
    snap_t       snap;
  } mul_slot_t;

  // Configuration registers.
  logic [31:0] dflt_dur_q, dflt_size_q, max_q;

  // Per-box parse state.
  logic [PosW-1:0]          pos_q, pos_d;
  logic                     has_off_q, has_off_d;
  logic                     has_ff_q, has_ff_d;
  logic [RecFieldCount-1:0] rf_q, rf_d;
  logic [23:0]              shift_q, shift_d;
  logic [31:0]              left_q, left_d;
  logic [3:0]               rec_q, rec_d;
  logic                     pdv_q, pdv_d, psv_q, psv_d;
  logic [31:0]              pd_q, pd_d, ps_q, ps_d;

  // Per-fragment state that the parser needs at once.
  logic [31:0] tot_q, tot_d;
  logic [31:0] room_q, room_d;
  logic [31:0] runs_q, runs_d;
  logic        offs_q, offs_d;
  logic [31:0] saved_q, saved_d;

  // Pipeline and accumulators.
  cnt_slot_t   s1_q, s1_d;
  mul_slot_t   s2_q, s2_d;
  logic [63:0] acc_dur_q, acc_dur_d, acc_bytes_q, acc_bytes_d;
  logic        out_valid_q;
  tfrp_out_t   out_data_q;
  logic        adv, accept;

  // Parse-stage intermediates.
  logic                     clr_box, clr_frag, last;
  logic [PosW-1:0]          p, pos_inc;
  logic                     has_off, has_ff;
  logic [RecFieldCount-1:0] rf;
  logic [31:0]              fs, left_mid;
  logic [3:0]               rec_e;
  logic                     pdv_mid, psv_mid;
  logic [31:0]              pd_mid, ps_mid;
  logic [31:0]              tot_e, room_e, runs_e;
  logic [PosW-1:0]          hdr_len, rec_len;
  logic [2:0]               nfields;
  logic                     in_hdr, in_opt, active, c1, ignored, fin;
  logic [1:0]               slot;
  logic [31:0]              a_cnt, cnt;
  logic                     special;

  // The pipeline only waits when a result would overwrite an untaken one.
  assign adv        = !(s2_q.res && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // Byte parser and sample count.
  always_comb begin
    clr_box  = in_data_i.box_first;
    clr_frag = in_data_i.box_first & in_data_i.new_fragment;
    last     = in_data_i.box_last;

    p       = clr_box ? '0 : pos_q;
    has_off = clr_box ? 1'b0 : has_off_q;
    has_ff  = clr_box ? 1'b0 : has_ff_q;
    rf      = clr_box ? '0 : rf_q;
    rec_e   = clr_box ? '0 : rec_q;
    pdv_mid = clr_box ? 1'b0 : pdv_q;
    psv_mid = clr_box ? 1'b0 : psv_q;
    pd_mid  = pd_q;
    ps_mid  = ps_q;
    fs      = {(clr_box ? 24'd0 : shift_q), in_data_i.data_byte};

    tot_e  = clr_frag ? '0 : tot_q;
    room_e = clr_frag ? max_q : room_q;
    runs_e = clr_frag ? '0 : runs_q;

    has_off_d = has_off;
    has_ff_d  = has_ff;
    rf_d      = rf;
    left_mid  = clr_box ? '0 : left_q;
    runs_d    = runs_e;
    offs_d    = clr_frag ? 1'b0 : offs_q;
    saved_d   = clr_frag ? '0 : saved_q;
    rec_d     = rec_e;

    hdr_len = HdrBase + (has_off ? OptFieldLen : '0) + (has_ff ? OptFieldLen : '0);
    in_hdr  = p < HdrBase;
    in_opt  = !in_hdr && (p < hdr_len);

    nfields = 3'(rf[0]) + 3'(rf[1]) + 3'(rf[2]) + 3'(rf[3]);
    rec_len = {nfields, 2'b00};

    if (in_hdr && p == PosFlagsEnd) begin
      has_off_d = fs[FlagDataOffset];
      has_ff_d  = fs[FlagFirstFlags];
      rf_d      = fs[FlagDuration +: RecFieldCount];
    end
    if (in_hdr && p == PosCountEnd) begin
      left_mid = fs;
      runs_d   = runs_e + 32'd1;
      if (runs_d == 32'd1) begin
        offs_d = has_off;
      end
    end
    if (in_opt && has_off && p == PosOffsetEnd && runs_e == 32'd1) begin
      saved_d = fs;
    end

    // Record bytes: a field counts once its fourth byte is in.
    active = !in_hdr && !in_opt && (rf != '0) && (left_mid != '0);
    slot   = rec_e[3:2];
    c1     = 1'b0;
    if (active) begin
      if (rec_e[1:0] == 2'b11) begin
        if (rf[0] && slot == 2'd0) begin
          pdv_mid = 1'b1;
          pd_mid  = fs;
        end
        if (rf[1] && slot == {1'b0, rf[0]}) begin
          psv_mid = 1'b1;
          ps_mid  = fs;
        end
      end
      c1    = ({1'b0, rec_e} + 5'd1) >= rec_len;
      rec_d = c1 ? '0 : rec_e + 4'd1;
    end

    pos_inc = (p == PosSat) ? p : p + 5'd1;
    ignored = pos_inc < HdrBase;
    fin     = last && !ignored;

    // At box end every sample still open or unread is counted; before that
    // only the sample that this byte closes. The cap limits both.
    a_cnt   = fin ? left_mid : {31'd0, c1};
    cnt     = (a_cnt < room_e) ? a_cnt : room_e;
    special = cnt != '0;
    tot_d   = tot_e + cnt;
    room_d  = room_e - cnt;

    left_d = c1 ? left_mid - 32'd1 : left_mid;
    pdv_d  = c1 ? 1'b0 : pdv_mid;
    psv_d  = c1 ? 1'b0 : psv_mid;
    pd_d   = pd_mid;
    ps_d   = ps_mid;
    pos_d  = pos_inc;
    shift_d = fs[23:0];

    if (last) begin
      pos_d     = '0;
      has_off_d = 1'b0;
      has_ff_d  = 1'b0;
      rf_d      = '0;
      left_d    = '0;
      rec_d     = '0;
      pdv_d     = 1'b0;
      psv_d     = 1'b0;
    end

    // The first counted sample carries the partial fields; the rest of
    // the count takes the defaults through the multiply stage.
    s1_d.clr          = clr_frag;
    s1_d.res          = last;
    s1_d.mcnt         = special ? cnt - 32'd1 : '0;
    s1_d.xdur         = special ? (pdv_mid ? pd_mid : dflt_dur_q) : '0;
    s1_d.xsize        = special ? (psv_mid ? ps_mid : dflt_size_q) : '0;
    s1_d.snap.samples = tot_d;
    s1_d.snap.runs    = runs_d;
    s1_d.snap.offset_flag = offs_d;
    s1_d.snap.offset  = saved_d;
    s1_d.snap.ignored = ignored;
  end

  // Multiply stage.
  always_comb begin
    s2_d.clr   = s1_q.clr;
    s2_d.res   = s1_q.res;
    s2_d.pdur  = {32'd0, s1_q.mcnt} * {32'd0, dflt_dur_q};
    s2_d.psize = {32'd0, s1_q.mcnt} * {32'd0, dflt_size_q};
    s2_d.xdur  = s1_q.xdur;
    s2_d.xsize = s1_q.xsize;
    s2_d.snap  = s1_q.snap;
  end

  // Accumulate stage: a fragment clear comes before the byte's own sums.
  assign acc_dur_d   = (s2_q.clr ? 64'd0 : acc_dur_q) + s2_q.pdur + {32'd0, s2_q.xdur};
  assign acc_bytes_d = (s2_q.clr ? 64'd0 : acc_bytes_q) + s2_q.psize + {32'd0, s2_q.xsize};

  // Configuration registers; room follows a new cap at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_dur_q  <= '0;
      dflt_size_q <= '0;
      max_q       <= MaxSamplesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDefaultDuration: dflt_dur_q  <= cfg_data_i;
        CfgDefaultSize:     dflt_size_q <= cfg_data_i;
        CfgMaxSamples:      max_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parse state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      has_off_q <= 1'b0;
      has_ff_q  <= 1'b0;
      rf_q      <= '0;
      left_q    <= '0;
      rec_q     <= '0;
      pdv_q     <= 1'b0;
      psv_q     <= 1'b0;
      tot_q     <= '0;
      room_q    <= MaxSamplesReset;
      runs_q    <= '0;
      offs_q    <= 1'b0;
      saved_q   <= '0;
    end else begin
      if (accept) begin
        pos_q     <= pos_d;
        has_off_q <= has_off_d;
        has_ff_q  <= has_ff_d;
        rf_q      <= rf_d;
        left_q    <= left_d;
        rec_q     <= rec_d;
        pdv_q     <= pdv_d;
        psv_q     <= psv_d;
        tot_q     <= tot_d;
        runs_q    <= runs_d;
        offs_q    <= offs_d;
        saved_q   <= saved_d;
      end
      if (cfg_we_i && cfg_idx_i == CfgMaxSamples) begin
        room_q <= (cfg_data_i > tot_q) ? cfg_data_i - tot_q : '0;
      end else if (accept) begin
        room_q <= room_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      shift_q <= shift_d;
      pd_q    <= pd_d;
      ps_q    <= ps_d;
    end
  end

  // Pipeline, accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      acc_dur_q   <= '0;
      acc_bytes_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_q        <= accept ? s1_d : '0;
      s2_q        <= s2_d;
      acc_dur_q   <= acc_dur_d;
      acc_bytes_q <= acc_bytes_d;
      if (s2_q.res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_q.res) begin
      out_data_q.fragment_samples  <= s2_q.snap.samples;
      out_data_q.fragment_duration <= acc_dur_d;
      out_data_q.fragment_bytes    <= acc_bytes_d;
      out_data_q.run_count         <= s2_q.snap.runs;
      out_data_q.offset_flag       <= s2_q.snap.offset_flag;
      out_data_q.first_offset      <= s2_q.snap.offset;
      out_data_q.box_ignored       <= s2_q.snap.ignored;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ src/tfrp_checker.sv @@
// Port-level checker of the trun parser core and its bind.
// Depends on tfrp_pkg and track_fragment_run_parser_core_defines.svh.
`include "track_fragment_run_parser_core_defines.svh"

module tfrp_checker
  import tfrp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input tfrp_out_t out_data_o
);

  // No result can come out of a pipeline that reset has just emptied.
  `TFRP_ASSERT_ALWAYS(a_no_word_after_reset, !rst_ni |=> !out_valid_o, "word right after reset")

  // Input only waits behind an untaken result.
  `TFRP_ASSERT(a_ready_when_drained, !out_valid_o || out_ready_i |-> in_ready_o, "input stalled with free output")

  // Durations and sizes only grow when a sample is counted.
  `TFRP_ASSERT(a_zero_samples_zero_sums, out_valid_o && (out_data_o.fragment_samples == 32'd0) |-> (out_data_o.fragment_duration == 64'd0) && (out_data_o.fragment_bytes == 64'd0), "sums without samples")

  `TFRP_ASSERT(a_out_valid_holds, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")

  `TFRP_ASSERT(a_out_word_holds, out_valid_o && !out_ready_i |=> $stable(out_data_o), "result changed while stalled")

endmodule

bind track_fragment_run_parser_core tfrp_checker u_tfrp_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench of track_fragment_run_parser_core: random and directed trun payloads,
// checked word by word against a fragment total predictor. Depends on tfrp_pkg.

import tfrp_pkg::*;

// Predicts the fragment totals that the core reports at each box end and
// checks every returned word against the oldest prediction.
class run_scoreboard;
  bit [31:0] dflt_dur, dflt_size, sample_cap;

  // Open box state.
  bit [31:0] pos, declared, shreg, done_cnt, rec_idx;
  bit [23:0] flags;
  bit        dur_ok, size_ok;
  bit [31:0] dur_val, size_val;

  // Fragment state.
  bit [31:0] samples, runs, offs_val;
  bit [63:0] dur_sum, byte_sum;
  bit        offs_seen;

  tfrp_out_t totals_q[$];
  int        errors;
  int        predicted;

  function new();
    dflt_dur   = '0;
    dflt_size  = '0;
    sample_cap = MaxSamplesReset;
    errors     = 0;
    predicted  = 0;
    clear_box();
    clear_fragment();
  endfunction

  function void clear_box();
    pos      = '0;
    flags    = '0;
    declared = '0;
    shreg    = '0;
    done_cnt = '0;
    rec_idx  = '0;
    dur_ok   = 1'b0;
    size_ok  = 1'b0;
    dur_val  = '0;
    size_val = '0;
  endfunction

  function void clear_fragment();
    samples   = '0;
    dur_sum   = '0;
    byte_sum  = '0;
    runs      = '0;
    offs_seen = 1'b0;
    offs_val  = '0;
  endfunction

  function void set_reg(tfrp_cfg_e idx, bit [31:0] val);
    case (idx)
      CfgDefaultDuration: dflt_dur = val;
      CfgDefaultSize:     dflt_size = val;
      CfgMaxSamples:      sample_cap = val;
      default: ;
    endcase
  endfunction

  // Counts the sample in progress, with defaults for the fields it lacks.
  function void count_sample();
    if (samples < sample_cap) begin
      samples++;
      dur_sum  += dur_ok ? 64'(dur_val) : 64'(dflt_dur);
      byte_sum += size_ok ? 64'(size_val) : 64'(dflt_size);
    end
    done_cnt++;
    dur_ok  = 1'b0;
    size_ok = 1'b0;
  endfunction

  function void note_word(tfrp_in_t w);
    bit [31:0] hdr, len, slot, kind, rest, room, n;
    bit        ignored;
    tfrp_out_t want;
    if (w.box_first) begin
      if (w.new_fragment) clear_fragment();
      clear_box();
    end
    shreg = {shreg[23:0], w.data_byte};
    if (pos < 32'(HdrBase)) begin
      if (pos == 32'(PosFlagsEnd)) flags = shreg[23:0];
      if (pos == 32'(PosCountEnd)) begin
        declared = shreg;
        runs++;
        if (runs == 1) offs_seen = flags[FlagDataOffset];
      end
    end else begin
      hdr = 32'(HdrBase) + (flags[FlagDataOffset] ? 32'(OptFieldLen) : 32'd0)
          + (flags[FlagFirstFlags] ? 32'(OptFieldLen) : 32'd0);
      if (pos < hdr) begin
        if (flags[FlagDataOffset] && pos == 32'(PosOffsetEnd) && runs == 1) offs_val = shreg;
      end else begin
        len = 0;
        for (int k = 0; k < RecFieldCount; k++) begin
          if (flags[FlagDuration + k]) len += 32'(OptFieldLen);
        end
        if (len != 0 && done_cnt < declared) begin
          if (rec_idx[1:0] == 2'd3) begin
            // Map the slot number within the record to the field it holds.
            slot = rec_idx >> 2;
            kind = RecFieldCount;
            for (int k = 0; k < RecFieldCount; k++) begin
              if (flags[FlagDuration + k] && kind == RecFieldCount) begin
                if (slot == 0) kind = FlagDuration + k;
                else slot--;
              end
            end
            if (kind == FlagDuration) begin
              dur_ok  = 1'b1;
              dur_val = shreg;
            end else if (kind == FlagSize) begin
              size_ok  = 1'b1;
              size_val = shreg;
            end
          end
          if (rec_idx + 1 >= len) begin
            count_sample();
            rec_idx = 0;
          end else begin
            rec_idx++;
          end
        end
      end
    end
    if (pos != 32'hFFFF_FFFF) pos++;
    if (!w.box_last) return;

    ignored = (pos < 32'(HdrBase));
    if (!ignored) begin
      // The sample in progress keeps what it completed; the unread ones
      // take the defaults, up to the cap.
      if (done_cnt < declared) count_sample();
      rest = declared - ((done_cnt < declared) ? done_cnt : declared);
      if (samples < sample_cap && rest > 0) begin
        room = sample_cap - samples;
        n = (rest < room) ? rest : room;
        samples  += n;
        dur_sum  += 64'(n) * 64'(dflt_dur);
        byte_sum += 64'(n) * 64'(dflt_size);
      end
    end
    clear_box();
    want.fragment_samples  = samples;
    want.fragment_duration = dur_sum;
    want.fragment_bytes    = byte_sum;
    want.run_count         = runs;
    want.offset_flag       = offs_seen;
    want.first_offset      = offs_val;
    want.box_ignored       = ignored;
    totals_q.push_back(want);
    predicted++;
  endfunction

  function void compare(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  function void check_word(tfrp_out_t got);
    tfrp_out_t want;
    if (totals_q.size() == 0) begin
      $error("result word with no expected word waiting");
      errors++;
      return;
    end
    want = totals_q.pop_front();
    compare("fragment_samples", want.fragment_samples, got.fragment_samples);
    compare("fragment_duration", want.fragment_duration, got.fragment_duration);
    compare("fragment_bytes", want.fragment_bytes, got.fragment_bytes);
    compare("run_count", want.run_count, got.run_count);
    compare("offset_flag", want.offset_flag, got.offset_flag);
    compare("first_offset", want.first_offset, got.first_offset);
    compare("box_ignored", want.box_ignored, got.box_ignored);
  endfunction

  function int pending();
    return totals_q.size();
  endfunction
endclass

module tb;

  // Generous bound on the whole run; the slowest legal run stays far below.
  localparam int CycleLimit = 600000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  tfrp_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  tfrp_out_t   out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  run_scoreboard board;
  int            cycles;
  int            words_sent;

  track_fragment_run_parser_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycles >= CycleLimit);
    $display("Mismatches found");
    $finish;
  end

  // Outputs are sampled at the rising edge; the core updates its registers
  // with nonblocking assignments, so this sees the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_word(out_data_o);
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // The receiver alternates runs of ready with stalls of random length.
  // Every change happens at its own falling edge.
  initial begin
    int unsigned hold, stall;
    @(posedge rst_ni);
    forever begin
      hold = $urandom_range(1, 40);
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (hold - 1) @(negedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // Presents one word and waits for its handshake. Valid is only lowered
  // when a gap is wanted, so back-to-back words never see a low/high glitch.
  task automatic send_word(input tfrp_in_t w, input bit burst);
    int unsigned gap;
    gap = burst ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_word(w);
    words_sent++;
  endtask

  // Sends payload bytes as one box. A dropped start mark or end mark builds
  // the broken framings; new_fragment now and then shows up on a middle byte,
  // where the core has to ignore it.
  task automatic send_box(input bit [7:0] body[$], input bit mark_first,
                          input bit fresh, input bit close);
    tfrp_in_t w;
    bit       burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (body[i]) begin
      w.data_byte    = body[i];
      w.box_first    = mark_first && (i == 0);
      w.box_last     = close && (i == body.size() - 1);
      w.new_fragment = (i == 0) ? fresh : ($urandom_range(0, 15) == 0);
      send_word(w, burst);
    end
  endtask

  function automatic void push32(ref bit [7:0] q[$], input bit [31:0] val);
    for (int k = 3; k >= 0; k--) q.push_back(val[8*k +: 8]);
  endfunction

  // Builds a payload: version and flags, sample count, the optional data
  // offset and first-sample flags, then recs records of the flagged fields.
  function automatic void make_payload(ref bit [7:0] body[$], input bit [23:0] flg,
                                       input bit [31:0] count, input bit [31:0] offs,
                                       input int unsigned recs);
    int unsigned roll;
    body.delete();
    push32(body, {8'($urandom), flg});
    push32(body, count);
    if (flg[FlagDataOffset]) push32(body, offs);
    if (flg[FlagFirstFlags]) push32(body, $urandom);
    repeat (recs) begin
      for (int k = 0; k < RecFieldCount; k++) begin
        if (flg[FlagDuration + k]) begin
          roll = $urandom_range(0, 7);
          push32(body, (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom);
        end
      end
    end
  endfunction

  // Stops the sender until every expected word is back, then lets the
  // core's pipeline run dry before anything else happens.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles; only called idle.
  task automatic program_regs(input bit [31:0] dur, input bit [31:0] size,
                              input bit [31:0] cap);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgDefaultDuration;
    cfg_data_i <= dur;
    board.set_reg(CfgDefaultDuration, dur);
    @(negedge clk_i);
    cfg_idx_i  <= CfgDefaultSize;
    cfg_data_i <= size;
    board.set_reg(CfgDefaultSize, size);
    @(negedge clk_i);
    cfg_idx_i  <= CfgMaxSamples;
    cfg_data_i <= cap;
    board.set_reg(CfgMaxSamples, cap);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random box. Most boxes are well formed with random content, so the
  // record walk and the box-end fill are exercised; the rest are truncated,
  // short, abandoned or missing their start mark.
  task automatic random_box();
    bit [7:0]    body[$];
    bit [23:0]   flg;
    bit [31:0]   count, offs;
    bit          fresh;
    int unsigned roll, recs, cut;
    flg = 24'($urandom);
    flg[FlagDataOffset] = $urandom_range(0, 1);
    flg[FlagFirstFlags] = $urandom_range(0, 1);
    for (int k = 0; k < RecFieldCount; k++) flg[FlagDuration + k] = $urandom_range(0, 1);
    roll = $urandom_range(0, 99);
    if (roll < 70) count = $urandom_range(0, 4);
    else if (roll < 85) count = $urandom_range(5, 12);
    else count = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
    recs = (count <= 4) ? count : $urandom_range(0, 3);
    roll = $urandom_range(0, 9);
    offs = (roll == 0) ? 32'h8000_0000 : (roll == 1) ? 32'h7FFF_FFFF : $urandom;
    make_payload(body, flg, count, offs, recs);
    fresh = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 72) begin
      // Well formed, sometimes with surplus bytes after the records.
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));
      end
      send_box(body, 1'b1, fresh, 1'b1);
    end else if (roll < 82) begin
      cut = $urandom_range(1, body.size());
      send_box(body[0:cut-1], 1'b1, fresh, 1'b1);
    end else if (roll < 88) begin
      send_box(body[0:$urandom_range(0, 6)], 1'b1, fresh, 1'b1);
    end else if (roll < 94) begin
      // Left open: the next start mark drops it without a result.
      cut = $urandom_range(1, body.size() - 1);
      send_box(body[0:cut-1], 1'b1, fresh, 1'b0);
    end else begin
      send_box(body, 1'b0, fresh, 1'b1);
    end
    if ($urandom_range(0, 19) == 0) settle();
  endtask

  initial begin
    bit [7:0] body[$];
    int       phase_end;
    board       = new();
    cycles      = 0;
    words_sent  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgDefaultDuration;
    cfg_data_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    program_regs($urandom, $urandom, MaxSamplesReset);

    // Short boxes: three bytes, then seven bytes that hold the flags.
    body = '{8'h00, 8'hFF, 8'h01};
    send_box(body, 1'b1, 1'b1, 1'b1);
    make_payload(body, 24'h000F05, 32'd5, 32'd0, 0);
    send_box(body[0:6], 1'b1, 1'b0, 1'b1);
    // Header only with no record fields: every sample takes the defaults.
    make_payload(body, 24'h000000, 32'd3, 32'd0, 0);
    send_box(body, 1'b1, 1'b0, 1'b1);
    // Every field present, most negative data offset in the first run.
    make_payload(body, 24'h000F05, 32'd2, 32'h8000_0000, 2);
    send_box(body, 1'b1, 1'b1, 1'b1);
    // A later run's data offset must not replace the first one.
    make_payload(body, 24'h000F01, 32'd1, 32'h7FFF_FFFF, 1);
    send_box(body, 1'b1, 1'b0, 1'b1);
    // Ends inside a record: the duration counts, the half size does not.
    make_payload(body, 24'h000300, 32'd4, 32'd0, 2);
    send_box(body[0:13], 1'b1, 1'b0, 1'b1);
    // Surplus bytes after the last declared record.
    make_payload(body, 24'h000200, 32'd1, 32'd0, 1);
    repeat (8) body.push_back(8'($urandom));
    send_box(body, 1'b1, 1'b0, 1'b1);
    // Restart: an open box dropped by the next start mark.
    make_payload(body, 24'h000B00, 32'd3, 32'd0, 3);
    send_box(body[0:11], 1'b1, 1'b0, 1'b0);
    make_payload(body, 24'h000100, 32'd2, 32'd0, 2);
    send_box(body, 1'b1, 1'b0, 1'b1);
    // Missing start mark, with a fragment mark that must be ignored.
    make_payload(body, 24'h000200, 32'd2, 32'd0, 2);
    send_box(body, 1'b0, 1'b1, 1'b1);
    // Huge sample count, filled up to the cap at box end.
    make_payload(body, 24'h000100, 32'hFFFF_FFFF, 32'd0, 2);
    send_box(body, 1'b1, 1'b1, 1'b1);
    // All-ones bytes throughout, then a one-byte box.
    body.delete();
    repeat (28) body.push_back(8'hFF);
    send_box(body, 1'b1, 1'b1, 1'b1);
    body = '{8'h5A};
    send_box(body, 1'b1, 1'b0, 1'b1);

    // Cap change: a small cap reached partway through a fragment.
    settle();
    program_regs(32'd7, 32'd11, 32'd3);
    make_payload(body, 24'h000000, 32'd5, 32'd0, 0);
    send_box(body, 1'b1, 1'b1, 1'b1);
    make_payload(body, 24'h000300, 32'd2, 32'd0, 2);
    send_box(body, 1'b1, 1'b0, 1'b1);

    // Random phases, each under its own register setting, extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: program_regs($urandom, $urandom, $urandom_range(2, 20));
        1: program_regs(32'h0, 32'h0, 32'h0);
        2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: program_regs($urandom_range(0, 255), $urandom, $urandom_range(100, 70000));
        default: program_regs($urandom, $urandom, $urandom);
      endcase
      phase_end = words_sent + 210;
      while (words_sent < phase_end || (ph == 4 && board.predicted < 60)) random_box();
    end

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
